[design/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// Text console character engine: shared package
// Screen geometry, operation codes, queue entry type and cell helpers.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int IDX_W  = 11;
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CELL_W-1:0] t_cell;

    localparam t_col  LAST_COL   = t_col'(COLUMNS - 1);
    localparam t_row  LAST_ROW   = t_row'(ROWS - 1);
    localparam t_idx  LAST_CELL  = t_idx'(CELL_COUNT - 1);
    localparam t_idx  END_CELL   = t_idx'(CELL_COUNT);
    localparam t_idx  COPY_LAST  = t_idx'(COPY_COUNT - 1);
    localparam t_idx  ROW_STRIDE = t_idx'(COLUMNS);
    localparam t_cell BLANK_CELL = 16'h0700;
    localparam t_byte COLOUR_RST = 8'h07;

    // Host commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Control bytes
    localparam t_byte CHAR_NL = 8'h0A;
    localparam t_byte CHAR_BS = 8'h08;
    localparam t_byte CHAR_CR = 8'h0D;

    // Classified operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
    localparam logic [OP_W-1:0] OP_PRINT     = 3'd1;
    localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd2;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_byte           char_code;
        t_byte           colour;
        t_idx            cell_index;
    } t_op;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    function automatic t_idx cell_pos(input t_row row, input t_col col);
        return t_idx'(t_idx'(row) * ROW_STRIDE) + t_idx'(col);
    endfunction

endpackage

[design/tcce_front.sv]
// ----------------------------------------------------------------------------
// Text console front end
// Holds the colour register, accepts commands and classifies them into
// operations for the queue.
// ----------------------------------------------------------------------------
module tcce_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcce_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]    i_cell_index,
    input  logic                          i_init_busy,
    output logic                          o_push,
    output tcce_pkg::t_op                 o_op,
    input  logic                          i_q_ready
);

    logic          r_valid;
    tcce_pkg::t_op r_op;
    tcce_pkg::t_byte r_text_colour;
    tcce_pkg::t_op n_op;
    logic          accept;

    assign o_in_ready = !i_init_busy && (!r_valid || i_q_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid;
    assign o_op       = r_op;

    always_comb begin
        n_op.char_code  = i_char_code;
        n_op.colour     = r_text_colour;
        n_op.cell_index = i_cell_index;
        n_op.op         = tcce_pkg::OP_NOP;
        case (i_cmd)
            tcce_pkg::CMD_PUT: begin
                if (i_char_code == tcce_pkg::CHAR_CR) begin
                    n_op.op = tcce_pkg::OP_NOP;
                end else if (i_char_code == tcce_pkg::CHAR_NL) begin
                    n_op.op = tcce_pkg::OP_NEWLINE;
                end else if (i_char_code == tcce_pkg::CHAR_BS) begin
                    n_op.op = tcce_pkg::OP_BACKSPACE;
                end else begin
                    n_op.op = tcce_pkg::OP_PRINT;
                end
            end
            tcce_pkg::CMD_CLEAR: begin
                n_op.op = tcce_pkg::OP_CLEAR;
            end
            tcce_pkg::CMD_READ: begin
                if (i_cell_index < tcce_pkg::END_CELL) begin
                    n_op.op = tcce_pkg::OP_READ;
                end
            end
            default: begin
                n_op.op = tcce_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_text_colour <= tcce_pkg::COLOUR_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_text_colour <= i_cfg_wr_data;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_q_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

[design/tcce_queue.sv]
// ----------------------------------------------------------------------------
// Text console operation queue
// Short FIFO between the front end and the cell engine.
// ----------------------------------------------------------------------------
module tcce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcce_pkg::t_op i_op,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output tcce_pkg::t_op o_op
);

    tcce_pkg::t_op                  r_data [tcce_pkg::QDEPTH];
    logic [tcce_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [tcce_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [tcce_pkg::QCNT_W-1:0]    r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_ready = (r_count != tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_data[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_op;
        end
    end

endmodule

[design/tcce_back.sv]
// ----------------------------------------------------------------------------
// Text console cell engine
// Owns the screen memory and cursor, runs each operation, sweeps the memory
// for clear and scroll, and holds the result register.
// ----------------------------------------------------------------------------
module tcce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tcce_pkg::t_op                 i_op,
    output logic                          o_pop,
    output logic                          o_init_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcce_pkg::IDX_W-1:0]    o_cursor_pos,
    output logic [tcce_pkg::BYTE_W-1:0]   o_cell_char,
    output logic [tcce_pkg::BYTE_W-1:0]   o_cell_attr
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_FILL   = 2'd3;

    tcce_pkg::t_cell mem [tcce_pkg::CELL_COUNT];

    logic [1:0]      r_state, n_state;
    logic            r_init, n_init;
    tcce_pkg::t_col  r_col, n_col;
    tcce_pkg::t_row  r_row, n_row;
    tcce_pkg::t_idx  r_rd_ptr, n_rd_ptr;
    tcce_pkg::t_idx  r_wr_ptr, n_wr_ptr;
    logic            r_pend, n_pend;
    tcce_pkg::t_cell r_rd_data;

    logic            r_out_valid, n_out_valid;
    tcce_pkg::t_idx  r_out_pos;
    tcce_pkg::t_byte r_out_char;
    tcce_pkg::t_byte r_out_attr;

    logic            mem_we;
    tcce_pkg::t_idx  mem_waddr;
    tcce_pkg::t_cell mem_wdata;
    logic            mem_re;
    tcce_pkg::t_idx  mem_raddr;

    logic            pop;
    logic            emit;
    tcce_pkg::t_byte emit_char;
    tcce_pkg::t_byte emit_attr;
    logic            step_row;
    tcce_pkg::t_idx  cur_pos;

    assign cur_pos      = tcce_pkg::cell_pos(r_row, r_col);
    assign pop          = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop        = pop;
    assign o_init_busy  = r_init;
    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_col       = r_col;
        n_row       = r_row;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_wr_ptr;
        mem_wdata   = tcce_pkg::BLANK_CELL;
        mem_re      = 1'b0;
        mem_raddr   = r_rd_ptr;
        emit        = 1'b0;
        emit_char   = '0;
        emit_attr   = '0;
        step_row    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    case (i_op.op)
                        tcce_pkg::OP_PRINT: begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_pos;
                            mem_wdata = {i_op.colour, i_op.char_code};
                            if (r_col == tcce_pkg::LAST_COL) begin
                                n_col    = '0;
                                step_row = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                                emit  = 1'b1;
                            end
                        end
                        tcce_pkg::OP_NEWLINE: begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_pos;
                            n_col     = '0;
                            step_row  = 1'b1;
                        end
                        tcce_pkg::OP_BACKSPACE: begin
                            if (r_col == '0) begin
                                n_col = tcce_pkg::LAST_COL;
                                if (r_row != '0) begin
                                    n_row = r_row - 1'b1;
                                end
                            end else begin
                                n_col = r_col - 1'b1;
                            end
                            if (cur_pos != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_pos - 1'b1;
                            end
                            emit = 1'b1;
                        end
                        tcce_pkg::OP_CLEAR: begin
                            n_col    = '0;
                            n_row    = '0;
                            n_wr_ptr = '0;
                            n_state  = S_FILL;
                        end
                        tcce_pkg::OP_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = i_op.cell_index;
                            n_state   = S_READ;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                    if (step_row) begin
                        if (r_row == tcce_pkg::LAST_ROW) begin
                            n_rd_ptr = tcce_pkg::ROW_STRIDE;
                            n_wr_ptr = '0;
                            n_state  = S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                            emit  = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                emit      = 1'b1;
                emit_char = r_rd_data[tcce_pkg::BYTE_W-1:0];
                emit_attr = r_rd_data[tcce_pkg::CELL_W-1:tcce_pkg::BYTE_W];
                n_state   = S_IDLE;
            end
            S_SCROLL: begin
                // copy pipeline: read one row ahead, write the cell behind
                if (r_rd_ptr != tcce_pkg::END_CELL) begin
                    mem_re   = 1'b1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                    n_pend   = 1'b1;
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                    n_wr_ptr  = r_wr_ptr + 1'b1;
                    if (r_wr_ptr == tcce_pkg::COPY_LAST) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                mem_we   = 1'b1;
                n_wr_ptr = r_wr_ptr + 1'b1;
                if (r_wr_ptr == tcce_pkg::LAST_CELL) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                    emit    = !r_init;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_col       <= n_col;
            r_row       <= n_row;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pos  <= tcce_pkg::cell_pos(n_row, n_col);
            r_out_char <= emit_char;
            r_out_attr <= emit_attr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

endmodule

[design/text_console_char_engine_top.sv]
// ----------------------------------------------------------------------------
// Text console character engine
// 80x25 character/attribute screen with cursor, put, clear and read commands.
// ----------------------------------------------------------------------------
// Clear: one cell write a cycle. Scroll: row copy via the separate read and
// write ports, then bottom row blanked. Simple puts sustain one item per cycle
// while the output is not stalled.
// Reset: cursor homed, colour 0x07; a clearing pass then runs, during which no
// item is accepted (configuration writes still taken).
module text_console_char_engine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcce_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]    i_cell_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcce_pkg::IDX_W-1:0]    o_cursor_pos,
    output logic [tcce_pkg::BYTE_W-1:0]   o_cell_char,
    output logic [tcce_pkg::BYTE_W-1:0]   o_cell_attr
);

    logic          init_busy;
    logic          push;
    tcce_pkg::t_op front_op;
    logic          q_ready;
    logic          q_valid;
    tcce_pkg::t_op q_op;
    logic          pop;

    tcce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_char_code   (i_char_code),
        .i_cell_index  (i_cell_index),
        .i_init_busy   (init_busy),
        .o_push        (push),
        .o_op          (front_op),
        .i_q_ready     (q_ready)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    tcce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_op         (q_op),
        .o_pop        (pop),
        .o_init_busy  (init_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Text console character engine: testbench
// Drives put, clear and read commands through the valid/ready input channel
// and checks every result against a cycle-free model of the screen, cursor
// and text colour. A short directed run covers the corner cases. Random
// phases follow, each setting a colour and one of four idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT      = 12_000_000;
    localparam int PHASE_GAP  = 16;
    localparam int TAIL_WAIT  = 2100;
    localparam int N_PHASES   = 6;
    localparam int PHASE_SIZE = 222;

    localparam logic [tcce_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [tcce_pkg::CMD_W-1:0] cmd;
        tcce_pkg::t_byte            code;
        tcce_pkg::t_idx             idx;
    } t_console_cmd;

    typedef struct {
        tcce_pkg::t_idx  cursor_pos;
        tcce_pkg::t_byte cell_char;
        tcce_pkg::t_byte cell_attr;
    } t_console_resp;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [tcce_pkg::BYTE_W-1:0]   i_cfg_wr_data = '0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [tcce_pkg::CMD_W-1:0]    i_cmd         = '0;
    logic [tcce_pkg::BYTE_W-1:0]   i_char_code   = '0;
    logic [tcce_pkg::IDX_W-1:0]    i_cell_index  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic [tcce_pkg::IDX_W-1:0]    o_cursor_pos;
    logic [tcce_pkg::BYTE_W-1:0]   o_cell_char;
    logic [tcce_pkg::BYTE_W-1:0]   o_cell_attr;

    text_console_char_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_char_code   (i_char_code),
        .i_cell_index  (i_cell_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cursor_pos  (o_cursor_pos),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr)
    );

    t_console_cmd  pending_cmds[$];
    t_console_resp expected_resps[$];

    tcce_pkg::t_cell shadow_screen [tcce_pkg::CELL_COUNT];
    int unsigned     shadow_col;
    int unsigned     shadow_row;
    tcce_pkg::t_byte shadow_colour;

    bit in_fire       = 1'b0;
    int n_pushed      = 0;
    int n_accepted    = 0;
    int n_results     = 0;
    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d, expected %0d",
                 n_results, what, got, want);
        fail_count++;
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < tcce_pkg::CELL_COUNT; i++) begin
            shadow_screen[i] = tcce_pkg::BLANK_CELL;
        end
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < tcce_pkg::COPY_COUNT; i++) begin
            shadow_screen[i] = shadow_screen[i + tcce_pkg::COLUMNS];
        end
        for (int i = tcce_pkg::COPY_COUNT; i < tcce_pkg::CELL_COUNT; i++) begin
            shadow_screen[i] = tcce_pkg::BLANK_CELL;
        end
    endfunction

    function automatic void shadow_put_byte(input tcce_pkg::t_byte c);
        int unsigned pos;
        pos = shadow_row * tcce_pkg::COLUMNS + shadow_col;
        if (c == tcce_pkg::CHAR_CR) begin
            return;
        end else if (c == tcce_pkg::CHAR_NL) begin
            if (pos < tcce_pkg::CELL_COUNT) shadow_screen[pos] = tcce_pkg::BLANK_CELL;
            shadow_col = 0;
            shadow_row++;
        end else if (c == tcce_pkg::CHAR_BS) begin
            if (shadow_col == 0) begin
                shadow_col = tcce_pkg::COLUMNS - 1;
                if (shadow_row > 0) shadow_row--;
            end else begin
                shadow_col--;
            end
            // nothing to blank before the first cell
            if (pos > 0 && pos - 1 < tcce_pkg::CELL_COUNT) begin
                shadow_screen[pos - 1] = tcce_pkg::BLANK_CELL;
            end
        end else begin
            if (pos < tcce_pkg::CELL_COUNT) shadow_screen[pos] = {shadow_colour, c};
            shadow_col++;
            if (shadow_col > tcce_pkg::COLUMNS - 1) begin
                shadow_col = 0;
                shadow_row++;
            end
        end
        while (shadow_row > tcce_pkg::ROWS - 1) begin
            scroll_screen();
            shadow_row--;
        end
    endfunction

    function automatic t_console_resp console_response(input t_console_cmd c);
        t_console_resp r;
        r.cell_char = '0;
        r.cell_attr = '0;
        case (c.cmd)
            tcce_pkg::CMD_PUT: shadow_put_byte(c.code);
            tcce_pkg::CMD_CLEAR: begin
                blank_screen();
                shadow_col = 0;
                shadow_row = 0;
            end
            tcce_pkg::CMD_READ: begin
                if (c.idx < tcce_pkg::CELL_COUNT) begin
                    r.cell_char = shadow_screen[c.idx][tcce_pkg::BYTE_W-1:0];
                    r.cell_attr = shadow_screen[c.idx][tcce_pkg::CELL_W-1:tcce_pkg::BYTE_W];
                end
            end
            default: ;
        endcase
        r.cursor_pos = tcce_pkg::t_idx'(shadow_row * tcce_pkg::COLUMNS + shadow_col);
        return r;
    endfunction

    // Model update and result check at the sampling edge
    always @(posedge i_clk) begin : watch_ports
        t_console_cmd  c;
        t_console_resp want;
        if (!i_rst_n) begin
            blank_screen();
            shadow_col    = 0;
            shadow_row    = 0;
            shadow_colour = tcce_pkg::COLOUR_RST;
            in_fire       = 1'b0;
        end else begin
            if (i_cfg_wr_en) shadow_colour = i_cfg_wr_data;
            if (o_out_valid && i_out_ready) begin
                if (expected_resps.size() == 0) begin
                    $display("unexpected result %0d: cursor_pos %0d", n_results, o_cursor_pos);
                    fail_count++;
                end else begin
                    want = expected_resps.pop_front();
                    if (o_cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", o_cursor_pos, want.cursor_pos);
                    if (o_cell_char !== want.cell_char)
                        report_mismatch("cell_char", o_cell_char, want.cell_char);
                    if (o_cell_attr !== want.cell_attr)
                        report_mismatch("cell_attr", o_cell_attr, want.cell_attr);
                end
                n_results++;
            end
            in_fire = i_in_valid && o_in_ready;
            if (in_fire) begin
                c.cmd  = i_cmd;
                c.code = i_char_code;
                c.idx  = i_cell_index;
                expected_resps.push_back(console_response(c));
                n_accepted++;
            end
        end
    end

    always @(negedge i_clk) begin : drive_items
        t_console_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                i_in_valid   <= 1'b1;
                i_cmd        <= c.cmd;
                i_char_code  <= c.code;
                i_cell_index <= c.idx;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_cmd(input logic [tcce_pkg::CMD_W-1:0] cmd,
                            input tcce_pkg::t_byte code, input tcce_pkg::t_idx idx);
        t_console_cmd c;
        c.cmd  = cmd;
        c.code = code;
        c.idx  = idx;
        pending_cmds.push_back(c);
        n_pushed++;
    endtask

    task automatic push_put(input tcce_pkg::t_byte code);
        push_cmd(tcce_pkg::CMD_PUT, code, tcce_pkg::t_idx'($urandom_range(2047)));
    endtask

    function automatic tcce_pkg::t_byte printable_byte();
        tcce_pkg::t_byte b;
        do b = tcce_pkg::t_byte'($urandom_range(255));
        while (b == tcce_pkg::CHAR_NL || b == tcce_pkg::CHAR_BS || b == tcce_pkg::CHAR_CR);
        return b;
    endfunction

    function automatic tcce_pkg::t_idx read_index();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return tcce_pkg::t_idx'($urandom_range(tcce_pkg::CELL_COUNT - 1));
        if (r < 90) begin
            return tcce_pkg::t_idx'($urandom_range(tcce_pkg::CELL_COUNT + 2,
                                                   tcce_pkg::CELL_COUNT - 3));
        end
        return tcce_pkg::t_idx'($urandom_range(2047));
    endfunction

    task automatic gen_phase(input int n_items);
        int start;
        int pick;
        int len;
        start = n_pushed;
        while (n_pushed - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
                repeat (len) begin
                    push_put(printable_byte());
                    if ($urandom_range(99) < 8) push_put(tcce_pkg::CHAR_BS);
                    if ($urandom_range(99) < 3) push_put(tcce_pkg::CHAR_CR);
                end
                if ($urandom_range(99) < 70) push_put(tcce_pkg::CHAR_NL);
            end else if (pick < 75) begin
                push_cmd(tcce_pkg::CMD_READ, tcce_pkg::t_byte'($urandom_range(255)),
                         read_index());
            end else if (pick < 83) begin
                repeat ($urandom_range(1, 5)) push_put(tcce_pkg::CHAR_BS);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3)) push_put(tcce_pkg::CHAR_NL);
            end else if (pick < 90) begin
                push_cmd(CMD_SPARE, tcce_pkg::t_byte'($urandom_range(255)),
                         tcce_pkg::t_idx'($urandom_range(2047)));
            end else if (pick < 91) begin
                push_cmd(tcce_pkg::CMD_CLEAR, tcce_pkg::t_byte'($urandom_range(255)),
                         tcce_pkg::t_idx'($urandom_range(2047)));
            end else begin
                push_put(tcce_pkg::t_byte'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || expected_resps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_colour(input tcce_pkg::t_byte value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct = (mode == 1) ? 69 : (mode == 3) ? 17 : 0;
        stall_pct     = (mode == 2) ? 69 : (mode == 3) ? 17 : 0;
    endtask

    initial begin : run_test
        tcce_pkg::t_byte colours [N_PHASES];
        int              modes   [N_PHASES];
        colours = '{8'h00, 8'hFF, 8'h00, 8'h1E, 8'h00, 8'h07};
        colours[2] = tcce_pkg::t_byte'($urandom_range(255));
        colours[4] = tcce_pkg::t_byte'($urandom_range(255));
        modes = '{1, 2, 3, 0, 2, 3};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset colour
        set_idling(0);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd0);
        push_cmd(tcce_pkg::CMD_READ, 8'hFF, tcce_pkg::LAST_CELL);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, tcce_pkg::END_CELL);
        push_cmd(tcce_pkg::CMD_READ, 8'hFF, 11'h7FF);
        push_cmd(CMD_SPARE, 8'hFF, 11'h7FF);
        push_put(8'h41);
        push_put(tcce_pkg::CHAR_CR);
        push_put(tcce_pkg::CHAR_BS);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd0);
        push_put(tcce_pkg::CHAR_BS);
        push_put(8'hFF);
        push_put(8'h00);
        push_put(tcce_pkg::CHAR_NL);
        push_put(tcce_pkg::CHAR_BS);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd79);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd80);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd81);
        push_cmd(tcce_pkg::CMD_CLEAR, 8'hFF, 11'h7FF);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd79);
        push_put(8'h7E);
        push_cmd(tcce_pkg::CMD_READ, 8'h00, 11'd0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            repeat (PHASE_GAP) @(posedge i_clk);
            write_colour(colours[p]);
            set_idling(modes[p]);
            gen_phase(PHASE_SIZE);
            wait_drained();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/tcce_pkg.sv
design/tcce_front.sv
design/tcce_queue.sv
design/tcce_back.sv
design/text_console_char_engine_top.sv
tb/testbench.sv
